FILE: rtl/hoh_pkg.sv
// shared types and constants for the hypergraph overlap histogram
`timescale 1ns / 1ps
package hoh_pkg;

   typedef enum logic [2:0] {
      KIND_EDGE_OFFSET = 3'd0,
      KIND_EDGE_MEMBER = 3'd1,
      KIND_NODE_OFFSET = 3'd2,
      KIND_NODE_EDGE   = 3'd3,
      KIND_RUN         = 3'd4,
      KIND_READ_BIN    = 3'd5,
      KIND_READ_MAX    = 3'd6,
      KIND_UNUSED      = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      CSR_EDGE_TOTAL  = 2'd0,
      CSR_RANGE_FIRST = 2'd1,
      CSR_RANGE_END   = 2'd2,
      CSR_OVERLAP_CAP = 2'd3
   } csr_index_type;

   localparam int KIND_W      = 3;
   localparam int INDEX_W     = 13;
   localparam int VALUE_W     = 14;
   localparam int DATA_W      = 19;
   localparam int BIN_W       = 20;
   localparam int COUNT_W     = 16;
   localparam int CAP_W       = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;

   localparam logic [COUNT_W-1:0] COUNT_LIMIT = {COUNT_W{1'b1}};
   localparam logic [BIN_W-1:0]   BIN_LIMIT   = {BIN_W{1'b1}};
   localparam logic [DATA_W-1:0]  SUM_LIMIT   = {DATA_W{1'b1}};

endpackage

FILE: rtl/hypergraph_overlap_histogram.sv
// top level: sparse hypergraph store with an iterative overlap counting sequencer
`timescale 1ns / 1ps
// A load or read item passes through request capture, a registered memory read
// into the result register, then the result handshake; a stalled result holds
// off the next item. A run item walks a single sequencer: it clears the
// histogram, the per-edge maxima and the overlap counts, then per hyperedge in
// range it sets up the member list, looks up each member node's incidence list
// (skipping a node number out of range), counts each visited incidence that names
// a later hyperedge below the total, and bins the clipped count of each touched
// hyperedge; finally it sums the histogram bins from one up to the cap for the
// pair total. The block takes no item while a run is in progress.
module hypergraph_overlap_histogram
   import hoh_pkg::*;
#(
   parameter int MAX_EDGES      = 1024,
   parameter int MAX_NODES      = 1024,
   parameter int MAX_INCIDENCES = 8192,
   parameter int MAX_CAP        = 255
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [KIND_W-1:0]      req_kind,
   input  logic [INDEX_W-1:0]     req_index,
   input  logic [VALUE_W-1:0]     req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [DATA_W-1:0]      rsp_read_data,
   output logic                   rsp_overflow,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int EW = $clog2(MAX_EDGES + 1);
   localparam int EA = $clog2(MAX_EDGES);
   localparam int NA = $clog2(MAX_NODES + 1);
   localparam int IA = $clog2(MAX_INCIDENCES);
   localparam int IW = $clog2(MAX_INCIDENCES + 1);
   localparam int HA = $clog2(MAX_CAP + 1);

   typedef enum logic [4:0] {
      ST_IDLE, ST_READ, ST_CLR, ST_E0, ST_E1, ST_E2, ST_P1, ST_N0, ST_N1,
      ST_N2, ST_L0, ST_L1, ST_L2, ST_T0, ST_T1, ST_T2, ST_T3, ST_BEST, ST_S0,
      ST_S1, ST_S2, ST_DONE
   } state_type;

   // memories
   logic [VALUE_W-1:0] edge_start_mem [MAX_EDGES+1];
   logic [VALUE_W-1:0] node_start_mem [MAX_NODES+1];
   logic [VALUE_W-1:0] edge_members_mem [MAX_INCIDENCES];
   logic [VALUE_W-1:0] node_edges_mem [MAX_INCIDENCES];
   logic [COUNT_W-1:0] count_mem [MAX_EDGES];
   logic [EA-1:0]      touched_mem [MAX_EDGES];
   logic [CAP_W-1:0]   max_mem [MAX_EDGES];
   logic [BIN_W-1:0]   hist_mem [MAX_CAP+1];

   state_type          state_ff;
   logic [14:0]        ridx_ff;
   logic [KIND_W-1:0]  rkind_ff;
   logic               rsp_valid_ff;
   logic [DATA_W-1:0]  rsp_data_ff;
   logic               overflow_ff;
   logic [10:0]        edge_total_ff, range_end_ff;
   logic [9:0]         range_first_ff;
   logic [CAP_W-1:0]   cap_reg_ff;

   logic [EW-1:0]      total_ff, stop_ff, e_ff;
   logic [CAP_W-1:0]   cap_ff, best_ff;
   logic [IW-1:0]      pos_ff, pend_ff, loc_ff, lend_ff;
   logic [EW-1:0]      touched_ff, k_ff;
   logic [EA-1:0]      other_ff;
   logic [DATA_W-1:0]  sum_ff;
   logic [10:0]        clr_ff;
   logic [HA-1:0]      h_wa_hold_ff;

   // registered memory read data
   logic [VALUE_W-1:0] es_q, ns_q, em_q, ne_q;
   logic [COUNT_W-1:0] cnt_q;
   logic [EA-1:0]      tl_q;
   logic [CAP_W-1:0]   mx_q;
   logic [BIN_W-1:0]   h_q;

   logic [EW:0]        es_ra;
   logic [NA:0]        ns_ra;
   logic [IA-1:0]      em_ra, ne_ra;
   logic [EA-1:0]      cnt_ra, tl_ra, mx_ra;
   logic [HA-1:0]      h_ra;

   logic               cnt_we, tl_we, mx_we, h_we;
   logic [EA-1:0]      cnt_wa, tl_wa, mx_wa;
   logic [HA-1:0]      h_wa;
   logic [COUNT_W-1:0] cnt_wd;
   logic [CAP_W-1:0]   mx_wd;
   logic [BIN_W-1:0]   h_wd;

   logic [CAP_W-1:0]   clipped;
   logic [IW-1:0]      clip_q;
   logic [DATA_W:0]    sum_add;

   function automatic logic [IW-1:0] clip_end(input logic [VALUE_W-1:0] v);
      logic [IW-1:0] r;
      if ({1'b0, v} > (VALUE_W+1)'(MAX_INCIDENCES))
         r = IW'(MAX_INCIDENCES);
      else
         r = IW'(v);
      return r;
   endfunction

   assign req_ready     = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_overflow  = overflow_ff;

   assign clipped = (cnt_q > COUNT_W'(cap_ff)) ? cap_ff : CAP_W'(cnt_q);
   assign clip_q  = clip_end(es_q);
   assign sum_add = {1'b0, sum_ff} + (DATA_W+1)'(h_q);

   // read address selection
   always_comb begin
      es_ra  = '0;
      ns_ra  = '0;
      em_ra  = pos_ff[IA-1:0];
      ne_ra  = loc_ff[IA-1:0];
      cnt_ra = other_ff;
      tl_ra  = k_ff[EA-1:0];
      mx_ra  = other_ff;
      h_ra   = HA'(k_ff);
      case (state_ff)
         ST_IDLE: begin
            es_ra = (EW+1)'(req_index);
            ns_ra = (NA+1)'(req_index);
            mx_ra = EA'(req_index);
            h_ra  = HA'(req_index);
         end
         ST_E0:   es_ra = (EW+1)'(e_ff);
         ST_E1:   es_ra = (EW+1)'(e_ff) + 1'b1;
         ST_N0:   ns_ra = (NA+1)'(em_q);
         ST_N1:   ns_ra = (NA+1)'(em_q) + 1'b1;
         ST_L1:   cnt_ra = EA'(ne_q);
         ST_T0:   mx_ra = e_ff[EA-1:0];
         ST_T1:   begin
            cnt_ra = tl_q;
            mx_ra  = tl_q;
         end
         ST_T2:   h_ra = HA'(clipped);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      es_q  <= edge_start_mem[es_ra[EW-1:0]];
      ns_q  <= node_start_mem[ns_ra[NA-1:0]];
      em_q  <= edge_members_mem[em_ra];
      ne_q  <= node_edges_mem[ne_ra];
      cnt_q <= count_mem[cnt_ra];
      tl_q  <= touched_mem[tl_ra];
      mx_q  <= max_mem[mx_ra];
      h_q   <= hist_mem[h_ra];
      if (state_ff == ST_IDLE && req_valid && req_ready) begin
         case (req_kind)
            KIND_EDGE_OFFSET:
               if (req_index <= INDEX_W'(MAX_EDGES))
                  edge_start_mem[EW'(req_index)] <= req_value;
            KIND_EDGE_MEMBER:
               if ({1'b0, req_index} < (INDEX_W+1)'(MAX_INCIDENCES))
                  edge_members_mem[IA'(req_index)] <= req_value;
            KIND_NODE_OFFSET:
               if (req_index <= INDEX_W'(MAX_NODES))
                  node_start_mem[NA'(req_index)] <= req_value;
            KIND_NODE_EDGE:
               if ({1'b0, req_index} < (INDEX_W+1)'(MAX_INCIDENCES))
                  node_edges_mem[IA'(req_index)] <= req_value;
            default: ;
         endcase
      end
      if (cnt_we) count_mem[cnt_wa] <= cnt_wd;
      if (tl_we)  touched_mem[tl_wa] <= other_ff;
      if (mx_we)  max_mem[mx_wa] <= mx_wd;
      if (h_we)   hist_mem[h_wa] <= h_wd;
   end

   // memory write control
   always_comb begin
      cnt_we = 1'b0; cnt_wa = other_ff; cnt_wd = '0;
      tl_we  = 1'b0; tl_wa  = touched_ff[EA-1:0];
      mx_we  = 1'b0; mx_wa  = other_ff; mx_wd = '0;
      h_we   = 1'b0; h_wa   = HA'(clr_ff); h_wd = '0;
      case (state_ff)
         ST_CLR: begin
            // counts are left zero by every run; this pass covers reset too
            if (clr_ff < 11'(MAX_EDGES)) begin
               cnt_we = 1'b1; cnt_wa = EA'(clr_ff);
               mx_we  = 1'b1; mx_wa  = EA'(clr_ff);
            end
            if (clr_ff <= 11'(MAX_CAP)) h_we = 1'b1;
         end
         ST_L2: begin
            cnt_wa = other_ff;
            if (cnt_q == '0 && touched_ff < EW'(MAX_EDGES)) tl_we = 1'b1;
            if (cnt_q != COUNT_LIMIT) begin
               cnt_we = 1'b1; cnt_wd = cnt_q + 1'b1;
            end
         end
         ST_T2: begin
            cnt_we = 1'b1; cnt_wa = other_ff; cnt_wd = '0;
            if (clipped > mx_q) begin
               mx_we = 1'b1; mx_wa = other_ff; mx_wd = clipped;
            end
         end
         ST_T3: begin
            h_wa = h_wa_hold_ff;
            if (h_q != BIN_LIMIT) begin
               h_we = 1'b1; h_wd = h_q + 1'b1;
            end
         end
         ST_S2: ;
         default: ;
      endcase
      if (state_ff == ST_BEST && best_ff > mx_q) begin
         mx_we = 1'b1; mx_wa = e_ff[EA-1:0]; mx_wd = best_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLR;
         clr_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         overflow_ff    <= 1'b0;
         edge_total_ff  <= 11'd1024;
         range_first_ff <= '0;
         range_end_ff   <= 11'd1024;
         cap_reg_ff     <= 8'd255;
         rkind_ff       <= '0;
         touched_ff     <= '0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index_type'(csr_index))
               CSR_EDGE_TOTAL:  edge_total_ff  <= csr_data;
               CSR_RANGE_FIRST: range_first_ff <= csr_data[9:0];
               CSR_RANGE_END:   range_end_ff   <= csr_data;
               CSR_OVERLAP_CAP: cap_reg_ff     <= csr_data[CAP_W-1:0];
            endcase
         end
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: if (req_valid && req_ready) begin
               rkind_ff <= req_kind;
               ridx_ff  <= {2'b0, req_index};
               if (req_kind == KIND_RUN) begin
                  overflow_ff <= 1'b0;
                  clr_ff      <= '0;
                  total_ff    <= (edge_total_ff > 11'(MAX_EDGES)) ? EW'(MAX_EDGES)
                                                                  : EW'(edge_total_ff);
                  cap_ff      <= (cap_reg_ff == '0) ? CAP_W'(1) :
                                 (cap_reg_ff > CAP_W'(MAX_CAP)) ? CAP_W'(MAX_CAP)
                                                                : cap_reg_ff;
                  state_ff    <= ST_CLR;
               end else begin
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               rsp_valid_ff <= 1'b1;
               rsp_data_ff  <= '0;
               if (rkind_ff == KIND_READ_BIN && ridx_ff <= 15'(MAX_CAP))
                  rsp_data_ff <= h_q[DATA_W-1:0];
               if (rkind_ff == KIND_READ_MAX && ridx_ff < 15'(MAX_EDGES))
                  rsp_data_ff <= DATA_W'(mx_q);
               state_ff <= ST_IDLE;
            end
            ST_CLR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff >= 11'(MAX_EDGES) && clr_ff > 11'(MAX_CAP)) begin
                  stop_ff  <= (range_end_ff < 11'(total_ff)) ? EW'(range_end_ff)
                                                             : total_ff;
                  e_ff     <= EW'(range_first_ff);
                  state_ff <= (rkind_ff == KIND_RUN) ? ST_E0 : ST_IDLE;
               end
            end
            ST_E0: if (e_ff < stop_ff) begin
               state_ff   <= ST_E1;
               touched_ff <= '0;
               best_ff    <= '0;
            end else begin
               k_ff     <= EW'(1);
               sum_ff   <= '0;
               state_ff <= ST_S0;
            end
            ST_E1: begin
               pos_ff   <= IW'(es_q);
               state_ff <= ST_E2;
            end
            ST_E2: begin
               pend_ff  <= clip_q;
               state_ff <= ST_P1;
            end
            ST_P1: if (pos_ff < pend_ff) begin
               state_ff <= ST_N0;
            end else begin
               k_ff     <= '0;
               state_ff <= ST_T0;
            end
            ST_N0: if ({2'b0, em_q} >= (VALUE_W+2)'(MAX_NODES)) begin
               pos_ff   <= pos_ff + 1'b1;
               state_ff <= ST_P1;
            end else begin
               state_ff <= ST_N1;
            end
            ST_N1: begin
               loc_ff   <= IW'(ns_q);
               state_ff <= ST_N2;
            end
            ST_N2: begin
               lend_ff  <= clip_end(ns_q);
               state_ff <= ST_L0;
            end
            ST_L0: if (loc_ff < lend_ff) begin
               state_ff <= ST_L1;
            end else begin
               pos_ff   <= pos_ff + 1'b1;
               state_ff <= ST_P1;
            end
            ST_L1: begin
               loc_ff <= loc_ff + 1'b1;
               if ({1'b0, ne_q} <= (VALUE_W+1)'(e_ff) ||
                   {1'b0, ne_q} >= (VALUE_W+1)'(total_ff)) begin
                  state_ff <= ST_L0;
               end else begin
                  other_ff <= EA'(ne_q);
                  state_ff <= ST_L2;
               end
            end
            ST_L2: begin
               if (cnt_q == '0 && touched_ff < EW'(MAX_EDGES))
                  touched_ff <= touched_ff + 1'b1;
               if (cnt_q == COUNT_LIMIT) overflow_ff <= 1'b1;
               state_ff <= ST_L0;
            end
            ST_T0: if (k_ff < touched_ff) begin
               state_ff <= ST_T1;
            end else begin
               state_ff <= ST_BEST;
            end
            ST_T1: begin
               other_ff <= tl_q;
               state_ff <= ST_T2;
            end
            ST_T2: begin
               h_wa_hold_ff <= HA'(clipped);
               if (clipped > best_ff) best_ff <= clipped;
               state_ff <= ST_T3;
            end
            ST_T3: begin
               k_ff     <= k_ff + 1'b1;
               state_ff <= ST_T0;
            end
            ST_BEST: begin
               state_ff <= ST_E0;
               e_ff     <= e_ff + 1'b1;
            end
            ST_S0: state_ff <= ST_S1;
            ST_S1: state_ff <= ST_S2;
            ST_S2: begin
               sum_ff <= (sum_add > (DATA_W+1)'(SUM_LIMIT)) ? SUM_LIMIT
                                                            : sum_add[DATA_W-1:0];
               if (k_ff >= EW'(cap_ff)) begin
                  state_ff <= ST_DONE;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= ST_S0;
               end
            end
            ST_DONE: begin
               rsp_valid_ff <= 1'b1;
               rsp_data_ff  <= sum_ff;
               state_ff     <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_no_req_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready) else $error("ready while busy");
   a_rsp_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> rsp_valid) else $error("read item without result");
   a_touched_bound: assert property (@(posedge clock) disable iff (reset)
      touched_ff <= EW'(MAX_EDGES)) else $error("touched list overrun");
   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> (rsp_valid && rsp_read_data == $past(sum_ff)))
      else $error("run total lost");
`endif

endmodule

FILE: tb/sv/testbench.sv
// self-checking testbench for the hypergraph overlap histogram
`timescale 1ns / 1ps
module testbench;
   import hoh_pkg::*;

   localparam int N_EDGES = 1024;
   localparam int N_NODES = 1024;
   localparam int N_INC   = 8192;
   localparam int CAP_TOP = 255;

   typedef struct {
      kind_type          kind;
      logic [INDEX_W-1:0] index;
      logic [VALUE_W-1:0] value;
   } hg_item_type;

   typedef struct {
      logic [DATA_W-1:0] data;
      logic              ovf;
   } hg_answer_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [KIND_W-1:0]      req_kind;
   logic [INDEX_W-1:0]     req_index;
   logic [VALUE_W-1:0]     req_value;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [DATA_W-1:0]      rsp_read_data;
   logic                   rsp_overflow;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   hypergraph_overlap_histogram u_dut (.*);

   // shadow copy of the block state
   int hg_edge_start [0:N_EDGES];
   int hg_members    [0:N_INC-1];
   int hg_node_start [0:N_NODES];
   int hg_node_edges [0:N_INC-1];
   int hg_counts     [0:N_EDGES-1];
   int hg_touched    [0:N_EDGES-1];
   int hg_maxima     [0:N_EDGES-1];
   int hg_bins       [0:CAP_TOP];
   bit hg_ovf;
   int cfg_total, cfg_first, cfg_end, cfg_cap;

   hg_item_type   pending_items[$];
   hg_answer_type expected_answers[$];
   int         err_count;
   int         items_queued;
   int         send_idle_pct, recv_idle_pct;
   bit         req_taken;
   int         mem_hi, adj_hi;
   int         tmp_start  [0:N_EDGES];
   int         tmp_member [0:N_INC-1];

   function automatic int clip_inc(int v);
      return v > N_INC ? N_INC : v;
   endfunction

   function automatic int count_overlaps();
      int total, stop, cap, he, pos, loc, k, sum, node, lend, pend, other, touched, best, clipped;
      total = cfg_total < N_EDGES ? cfg_total : N_EDGES;
      stop  = cfg_end < total ? cfg_end : total;
      cap   = cfg_cap == 0 ? 1 : cfg_cap;
      if (cap > CAP_TOP) cap = CAP_TOP;
      sum = 0;
      foreach (hg_bins[i]) hg_bins[i] = 0;
      foreach (hg_maxima[i]) hg_maxima[i] = 0;
      hg_ovf = 0;
      for (he = cfg_first; he < stop; he++) begin
         touched = 0;
         best = 0;
         pend = clip_inc(hg_edge_start[he+1]);
         for (pos = hg_edge_start[he]; pos < pend; pos++) begin
            node = hg_members[pos];
            if (node < N_NODES) begin
               lend = clip_inc(hg_node_start[node+1]);
               for (loc = hg_node_start[node]; loc < lend; loc++) begin
                  other = hg_node_edges[loc];
                  if (other > he && other < total) begin
                     if (hg_counts[other] == 0 && touched < N_EDGES) begin
                        hg_touched[touched] = other;
                        touched++;
                     end
                     if (hg_counts[other] >= 65535) hg_ovf = 1;
                     else hg_counts[other]++;
                  end
               end
            end
         end
         for (k = 0; k < touched; k++) begin
            other = hg_touched[k];
            clipped = hg_counts[other] > cap ? cap : hg_counts[other];
            if (hg_bins[clipped] < 32'hFFFFF) hg_bins[clipped]++;
            if (clipped > best) best = clipped;
            if (clipped > hg_maxima[other]) hg_maxima[other] = clipped;
            hg_counts[other] = 0;
         end
         if (best > hg_maxima[he]) hg_maxima[he] = best;
      end
      for (k = 1; k <= cap; k++) begin
         sum += hg_bins[k];
         if (sum > 32'h7FFFF) sum = 32'h7FFFF;
      end
      return sum;
   endfunction

   function automatic hg_answer_type predict_answer(hg_item_type it);
      hg_answer_type a;
      int idx, val, d;
      idx = it.index;
      val = it.value;
      d = 0;
      case (it.kind)
         KIND_EDGE_OFFSET: if (idx <= N_EDGES) hg_edge_start[idx] = val;
         KIND_EDGE_MEMBER: hg_members[idx] = val;
         KIND_NODE_OFFSET: if (idx <= N_NODES) hg_node_start[idx] = val;
         KIND_NODE_EDGE:   hg_node_edges[idx] = val;
         KIND_RUN:         d = count_overlaps();
         KIND_READ_BIN:    if (idx <= CAP_TOP) d = hg_bins[idx];
         KIND_READ_MAX:    if (idx < N_EDGES) d = hg_maxima[idx];
         default: ;
      endcase
      a.data = d[DATA_W-1:0];
      a.ovf = hg_ovf;
      return a;
   endfunction

   task automatic report(string what, int got, int want);
      $display("%0t %s: got %0d, expected %0d", $realtime, what, got, want);
      err_count++;
   endtask

   task automatic push(kind_type k, int idx, int val);
      hg_item_type it;
      it.kind = k;
      it.index = idx[INDEX_W-1:0];
      it.value = val[VALUE_W-1:0];
      pending_items.push_back(it);
      items_queued++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (pending_items.size() != 0 || req_valid || expected_answers.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_register(csr_index_type idx, int val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val[CSR_DATA_W-1:0];
      do @(posedge clock); while (!(csr_valid && csr_ready));
      case (idx)
         CSR_EDGE_TOTAL:  cfg_total = val & 11'h7FF;
         CSR_RANGE_FIRST: cfg_first = val & 10'h3FF;
         CSR_RANGE_END:   cfg_end = val & 11'h7FF;
         CSR_OVERLAP_CAP: cfg_cap = val & 8'hFF;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_registers(int total, int first, int stop, int cap);
      write_register(CSR_EDGE_TOTAL, total);
      write_register(CSR_RANGE_FIRST, first);
      write_register(CSR_RANGE_END, stop);
      write_register(CSR_OVERLAP_CAP, cap);
   endtask

   // offsets only ever point inside the written part of the lists
   task automatic push_noise();
      int k, idx, val;
      k = $urandom_range(0, 6);
      if (k == KIND_RUN) k = KIND_UNUSED;
      idx = $urandom_range(0, 8191);
      val = $urandom_range(0, 8192);
      if (k == KIND_EDGE_OFFSET && idx <= N_EDGES) val = $urandom_range(0, mem_hi);
      if (k == KIND_NODE_OFFSET && idx <= N_NODES) val = $urandom_range(0, adj_hi);
      if (k == KIND_EDGE_MEMBER && val < N_NODES) val = $urandom_range(0, 15);
      push(kind_type'(k), idx, val);
   endtask

   task automatic build_graph(int n_he, int n_nodes, int max_len, bit noisy);
      int m, l, h, p, n;
      if (noisy) repeat ($urandom_range(0, 6)) push_noise();
      m = 0;
      for (h = 0; h < n_he; h++) begin
         tmp_start[h] = m;
         repeat ($urandom_range(0, max_len)) begin
            tmp_member[m] = ($urandom_range(0, 9) == 0) ? $urandom_range(N_NODES, 8192)
                                                       : $urandom_range(0, n_nodes - 1);
            m++;
         end
      end
      tmp_start[n_he] = m;
      for (h = 0; h <= n_he; h++) push(KIND_EDGE_OFFSET, h, tmp_start[h]);
      for (p = 0; p < m; p++) push(KIND_EDGE_MEMBER, p, tmp_member[p]);
      l = 0;
      for (n = 0; n < n_nodes; n++) begin
         push(KIND_NODE_OFFSET, n, l);
         for (h = 0; h < n_he; h++)
            for (p = tmp_start[h]; p < tmp_start[h+1]; p++)
               if (tmp_member[p] == n) begin
                  push(KIND_NODE_EDGE, l, h);
                  l++;
                  if ($urandom_range(0, 7) == 0) begin
                     push(KIND_NODE_EDGE, l, $urandom_range(0, 8192));
                     l++;
                  end
               end
      end
      push(KIND_NODE_OFFSET, n_nodes, l);
      if (mem_hi < m) mem_hi = m;
      if (adj_hi < l) adj_hi = l;
      if ($urandom_range(0, 5) == 0)
         push(KIND_EDGE_OFFSET, $urandom_range(0, n_he), $urandom_range(0, m));
      if ($urandom_range(0, 5) == 0)
         push(KIND_NODE_OFFSET, $urandom_range(0, n_nodes), $urandom_range(0, l));
   endtask

   task automatic push_reads(int n_he, int cap);
      for (int k = 0; k < 4; k++) push(KIND_READ_BIN, k, 0);
      push(KIND_READ_BIN, cap, 0);
      push(KIND_READ_BIN, $urandom_range(0, 8191), $urandom_range(0, 8192));
      for (int h = 0; h < n_he && h < 8; h++) push(KIND_READ_MAX, h, 0);
      push(KIND_READ_MAX, $urandom_range(0, n_he + 2), 0);
      push(KIND_READ_MAX, $urandom_range(0, 8191), 0);
      if ($urandom_range(0, 3) == 0) push(KIND_UNUSED, $urandom_range(0, 8191), 0);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("hypergraph_overlap_histogram: mismatch");
      $finish;
   end

   // driver
   always @(negedge clock) begin : drive_req
      logic nv;
      hg_item_type it;
      nv = req_valid;
      if (req_taken) begin
         nv = 1'b0;
         req_taken = 1'b0;
      end
      if (!reset && !nv && pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
         it = pending_items.pop_front();
         req_kind <= it.kind;
         req_index <= it.index;
         req_value <= it.value;
         nv = 1'b1;
      end
      req_valid <= nv;
      rsp_ready <= $urandom_range(0, 99) >= recv_idle_pct;
   end

   // monitor
   always @(posedge clock) begin : watch
      hg_item_type it;
      hg_answer_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            it.kind = kind_type'(req_kind);
            it.index = req_index;
            it.value = req_value;
            expected_answers.push_back(predict_answer(it));
            req_taken = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_answers.size() == 0) begin
               report("unexpected item", rsp_read_data, 0);
            end else begin
               want = expected_answers.pop_front();
               if (rsp_read_data !== want.data) report("read_data", rsp_read_data, want.data);
               if (rsp_overflow !== want.ovf) report("overflow", rsp_overflow, want.ovf);
            end
         end
      end
   end

   initial begin : stimulus
      int ep, ne, nn, cap, total, first, stop, r;
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = '0;
      req_index = '0;
      req_value = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_taken = 1'b0;
      err_count = 0;
      items_queued = 0;
      mem_hi = 0;
      adj_hi = 0;
      send_idle_pct = 22;
      recv_idle_pct = 76;
      cfg_total = 1024;
      cfg_first = 0;
      cfg_end = 1024;
      cfg_cap = 255;
      foreach (hg_edge_start[i]) hg_edge_start[i] = 0;
      foreach (hg_members[i]) hg_members[i] = 0;
      foreach (hg_node_start[i]) hg_node_start[i] = 0;
      foreach (hg_node_edges[i]) hg_node_edges[i] = 0;
      foreach (hg_counts[i]) hg_counts[i] = 0;
      foreach (hg_maxima[i]) hg_maxima[i] = 0;
      foreach (hg_bins[i]) hg_bins[i] = 0;
      hg_ovf = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // runs only reach the low offsets and the top hyperedge
      set_registers(1024, 1023, 1024, 255);
      for (int i = 0; i <= 64; i++) push(KIND_EDGE_OFFSET, i, 0);
      push(KIND_EDGE_OFFSET, 1023, 0);
      push(KIND_EDGE_OFFSET, 1024, 0);
      for (int i = 0; i <= 16; i++) push(KIND_NODE_OFFSET, i, 0);

      push(KIND_READ_BIN, 0, 0);
      push(KIND_READ_BIN, 255, 0);
      push(KIND_READ_BIN, 256, 0);
      push(KIND_READ_MAX, 1023, 0);
      push(KIND_READ_MAX, 8191, 16383);
      push(KIND_UNUSED, 8191, 8192);
      push(KIND_EDGE_OFFSET, 1025, 8192);
      push(KIND_NODE_OFFSET, 8191, 8192);
      push(KIND_EDGE_MEMBER, 8191, 8192);
      push(KIND_NODE_EDGE, 8191, 8192);
      push(KIND_RUN, 8191, 8192);
      push(KIND_READ_BIN, 1, 0);

      ep = 0;
      while (items_queued < 1700) begin
         wait_idle();
         if (items_queued < 600) begin
            send_idle_pct = 22;
            recv_idle_pct = 76;
         end else if (items_queued < 1200) begin
            send_idle_pct = 76;
            recv_idle_pct = 22;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         ep++;
         if (ep == 3) begin
            // overlap counter saturation
            set_registers(2, 0, 2, 255);
            push(KIND_EDGE_OFFSET, 0, 0);
            push(KIND_EDGE_OFFSET, 1, 256);
            push(KIND_EDGE_OFFSET, 2, 256);
            for (int p = 0; p < 256; p++) push(KIND_EDGE_MEMBER, p, 0);
            push(KIND_NODE_OFFSET, 0, 0);
            push(KIND_NODE_OFFSET, 1, 256);
            for (int p = 0; p < 256; p++) push(KIND_NODE_EDGE, p, 1);
            if (mem_hi < 256) mem_hi = 256;
            if (adj_hi < 256) adj_hi = 256;
            push(KIND_RUN, 0, 0);
            push_reads(2, 255);
         end else if (ep == 6) begin
            // list ends at the top of the incidence tables
            ne = $urandom_range(2, 10);
            nn = $urandom_range(1, 8);
            cap = $urandom_range(1, 4);
            set_registers(1024, ne - 1, ne, cap);
            build_graph(ne, nn, 6, 0);
            push(KIND_EDGE_OFFSET, ne - 1, 8188);
            push(KIND_EDGE_OFFSET, ne, 8192);
            push(KIND_NODE_OFFSET, nn - 1, 8188);
            push(KIND_NODE_OFFSET, nn, 8192);
            for (int p = 8188; p < 8192; p++) begin
               push(KIND_EDGE_MEMBER, p, ($urandom_range(0, 3) == 0) ? 1024 : nn - 1);
               push(KIND_NODE_EDGE, p, $urandom_range(ne - 1, ne + 3));
            end
            push(KIND_RUN, 0, 0);
            push_reads(ne + 4, cap);
            push(KIND_EDGE_OFFSET, ne - 1, 0);
            push(KIND_EDGE_OFFSET, ne, 0);
            push(KIND_NODE_OFFSET, nn - 1, 0);
            push(KIND_NODE_OFFSET, nn, 0);
         end else begin
            ne = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(2, 12);
            nn = $urandom_range(1, 16);
            r = $urandom_range(0, 9);
            total = (r < 6) ? ne : (r == 6) ? 1024 : (r == 7) ? 1 :
                    (r == 8) ? $urandom_range(1, 1024) : $urandom_range(ne, ne + 3);
            r = $urandom_range(0, 9);
            first = (r < 6) ? 0 : (r == 9) ? 1023 : $urandom_range(0, ne);
            r = $urandom_range(0, 9);
            stop = (r < 4) ? 1024 : (r < 7) ? ne : (r == 7) ? 1 :
                   (r == 8) ? first + 1 : $urandom_range(1, 1024);
            if (total > 64 && stop > 64 && first < 1023) stop = ne;
            r = $urandom_range(0, 5);
            cap = (r == 0) ? 1 : (r == 1) ? 255 : (r == 2) ? $urandom_range(1, 255)
                                                            : $urandom_range(1, 6);
            set_registers(total, first, stop, cap);
            build_graph(ne, nn, ($urandom_range(0, 3) == 0) ? 20 : 8, 1);
            push(KIND_RUN, $urandom_range(0, 8191), $urandom_range(0, 8192));
            push_reads(ne, cap);
            repeat ($urandom_range(0, 4)) push_noise();
         end
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (err_count == 0)
         $display("hypergraph_overlap_histogram: match");
      else
         $display("hypergraph_overlap_histogram: mismatch");
      $finish;
   end

endmodule
